// ===== hw/rtl/tcw_pkg.sv =====
// Shared types and constants of the text console character writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Fixed field widths of the item and result channels.
  localparam int ACTION_W = 1;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [ACTION_W-1:0] ACTION_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  typedef enum logic [2:0] {
    OP_READ,
    OP_NL,
    OP_CR,
    OP_TAB,
    OP_BS,
    OP_CHAR
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_READ,
    S_CHAR,
    S_TAB,
    S_COPY,
    S_DRAIN,
    S_BLANK,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic clear_step;
    logic scroll_start;
    logic copy_step;
    logic blank_step;
    logic scroll_done;
    logic rd;
    logic nl;
    logic cr;
    logic bs;
    logic put_char;
    logic put_tab;
    logic tab_load;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic pending;
    logic row_last;
    logic bs_ok;
    logic tab_last;
    logic copy_last;
    logic scan_last;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcw_item_if.sv =====
// Input channel: one character or read request per item.
`timescale 1ns / 1ps
`default_nettype none

interface tcw_item_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::ACTION_W-1:0]  action;
  logic [tcw_pkg::CHAR_W-1:0]    char_code;
  logic [tcw_pkg::INDEX_W-1:0]   read_index;

  modport source(output valid, action, char_code, read_index, input ready);
  modport sink(input valid, action, char_code, read_index, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tcw_result_if.sv =====
// Output channel: cursor, scroll flag and read cell per item.
`timescale 1ns / 1ps
`default_nettype none

interface tcw_result_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::CURSOR_W-1:0]  cursor_position;
  logic                          scrolled;
  logic [tcw_pkg::CELL_W-1:0]    read_cell;

  modport source(output valid, cursor_position, scrolled, read_cell, input ready);
  modport sink(input valid, cursor_position, scrolled, read_cell, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/text_console_char_writer.sv =====
// Top level of the text console character writer.
//
//   Channel   Direction  Handshake           Payload
//   item      in         valid/ready         action, char_code, read_index
//   result    out        valid/ready         cursor_position, scrolled, read_cell
//   apb       in/out     psel/penable        attribute register at address 0
//
// After reset the store is swept to blank cells; no item is taken until the sweep ends.
// Each item is taken, then decoded; a read or a printable character passes its own step
// before the final step, a return, newline or backspace goes straight to it, and a tab
// writes one blank a cycle unless a scroll falls due. A scroll copies the rows up one cell
// a cycle over the single write port, then blanks the bottom row. A stalled result holds
// the block in its final step; the next item is taken while the result waits.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  tcw_item_if.sink                               item,
  tcw_result_if.source                           result,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tcw_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [tcw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [tcw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  tcw_pkg::cmd_t              cmd;
  tcw_pkg::stat_t             stat;
  logic [tcw_pkg::ATTR_W-1:0] attribute;

  tcw_apb u_apb (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .attribute (attribute)
  );

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcw_dp #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .attribute       (attribute),
    .action          (item.action),
    .char_code       (item.char_code),
    .read_index      (item.read_index),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .cursor_position (result.cursor_position),
    .scrolled        (result.scrolled),
    .read_cell       (result.read_cell)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_apb.sv =====
// APB register slave holding the attribute byte.
`timescale 1ns / 1ps
`default_nettype none

module tcw_apb (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tcw_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [tcw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [tcw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output logic      [tcw_pkg::ATTR_W-1:0]        attribute
);

  logic hit;

  // Only the attribute register exists; it answers at every address with the top bit clear (0 to 3).
  assign hit    = (paddr[tcw_pkg::APB_ADDR_W-1] == 1'b0);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= tcw_pkg::RESET_ATTR;
    end else if (psel && penable && pwrite && hit) begin
      attribute <= pwdata[tcw_pkg::ATTR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata[tcw_pkg::ATTR_W-1:0] = attribute;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_ctrl.sv =====
// Controller state machine of the character writer.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tcw_pkg::stat_t  stat,
  output tcw_pkg::cmd_t        cmd
);

  tcw_pkg::state_t state, state_next;
  tcw_pkg::state_t resume, resume_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= tcw_pkg::S_CLEAR;
      resume <= tcw_pkg::S_FINISH;
    end else begin
      state  <= state_next;
      resume <= resume_next;
    end
  end

  // Next state; resume records where to go once a scroll has finished.
  always_comb begin
    state_next  = state;
    resume_next = resume;
    case (state)
      tcw_pkg::S_CLEAR: begin
        if (stat.scan_last) state_next = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_IDLE: begin
        if (in_valid) state_next = tcw_pkg::S_DECODE;
      end
      tcw_pkg::S_DECODE: begin
        case (stat.op)
          tcw_pkg::OP_READ: state_next = tcw_pkg::S_READ;
          tcw_pkg::OP_NL: begin
            if (stat.row_last) begin
              state_next  = tcw_pkg::S_COPY;
              resume_next = tcw_pkg::S_FINISH;
            end else begin
              state_next = tcw_pkg::S_FINISH;
            end
          end
          tcw_pkg::OP_TAB: state_next = tcw_pkg::S_TAB;
          tcw_pkg::OP_CHAR: begin
            if (stat.pending) begin
              state_next  = tcw_pkg::S_COPY;
              resume_next = tcw_pkg::S_CHAR;
            end else begin
              state_next = tcw_pkg::S_CHAR;
            end
          end
          default: state_next = tcw_pkg::S_FINISH;
        endcase
      end
      tcw_pkg::S_READ: state_next = tcw_pkg::S_FINISH;
      tcw_pkg::S_CHAR: state_next = tcw_pkg::S_FINISH;
      tcw_pkg::S_TAB: begin
        if (stat.pending) begin
          state_next  = tcw_pkg::S_COPY;
          resume_next = tcw_pkg::S_TAB;
        end else if (stat.tab_last) begin
          state_next = tcw_pkg::S_FINISH;
        end
      end
      tcw_pkg::S_COPY: begin
        if (stat.copy_last) state_next = tcw_pkg::S_DRAIN;
      end
      tcw_pkg::S_DRAIN: state_next = tcw_pkg::S_BLANK;
      tcw_pkg::S_BLANK: begin
        if (stat.scan_last) state_next = resume;
      end
      tcw_pkg::S_FINISH: begin
        if (!stat.out_busy) state_next = tcw_pkg::S_IDLE;
      end
      default: state_next = tcw_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      tcw_pkg::S_CLEAR: cmd.clear_step = 1'b1;
      tcw_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      tcw_pkg::S_DECODE: begin
        case (stat.op)
          tcw_pkg::OP_NL: begin
            cmd.nl           = !stat.row_last;
            cmd.scroll_start = stat.row_last;
          end
          tcw_pkg::OP_CR:   cmd.cr = 1'b1;
          tcw_pkg::OP_TAB:  cmd.tab_load = 1'b1;
          tcw_pkg::OP_BS:   cmd.bs = stat.bs_ok;
          tcw_pkg::OP_CHAR: cmd.scroll_start = stat.pending;
          default: ;
        endcase
      end
      tcw_pkg::S_READ: cmd.rd = 1'b1;
      tcw_pkg::S_CHAR: cmd.put_char = 1'b1;
      tcw_pkg::S_TAB: begin
        cmd.scroll_start = stat.pending;
        cmd.put_tab      = !stat.pending;
      end
      tcw_pkg::S_COPY: cmd.copy_step = 1'b1;
      tcw_pkg::S_BLANK: begin
        cmd.blank_step  = 1'b1;
        cmd.scroll_done = stat.scan_last;
      end
      tcw_pkg::S_FINISH: cmd.finish = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_dp.sv =====
// Datapath: screen store, cursor registers, scan counter and result register.
`timescale 1ns / 1ps
`default_nettype none

module tcw_dp #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire tcw_pkg::cmd_t                    cmd,
  output tcw_pkg::stat_t                        stat,
  input  wire logic [tcw_pkg::ATTR_W-1:0]       attribute,
  input  wire logic [tcw_pkg::ACTION_W-1:0]     action,
  input  wire logic [tcw_pkg::CHAR_W-1:0]       char_code,
  input  wire logic [tcw_pkg::INDEX_W-1:0]      read_index,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [tcw_pkg::CURSOR_W-1:0]     cursor_position,
  output logic                                  scrolled,
  output logic      [tcw_pkg::CELL_W-1:0]       read_cell
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int PW    = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int TCW   = $clog2(TAB_STOP + 1);

  localparam logic [tcw_pkg::CELL_W-1:0] RESET_CELL = {tcw_pkg::RESET_ATTR, tcw_pkg::CHAR_BLANK};

  logic [tcw_pkg::CELL_W-1:0] mem [CELLS];
  logic [tcw_pkg::CELL_W-1:0] rdata;

  // Latched item.
  tcw_pkg::op_t               op;
  logic [tcw_pkg::CHAR_W-1:0] ch;
  logic [tcw_pkg::INDEX_W-1:0] ridx;

  // Cursor kept as linear index plus row, column and column modulo the tab stop.
  logic [CW-1:0]  lin;
  logic [RW-1:0]  row;
  logic [CLW-1:0] col;
  logic [PW-1:0]  phase;
  logic [TCW-1:0] tabcnt;
  logic           scroll_flag;

  logic [AW-1:0]  scan;
  logic [AW-1:0]  scan_d;
  logic           wr_pend;

  tcw_pkg::op_t   op_dec;
  logic [RW-1:0]  adv_row;
  logic [CLW-1:0] adv_col;
  logic [PW-1:0]  adv_phase;
  logic           pending;
  logic [31:0]    ridx_w;
  logic [31:0]    lin_w;
  logic           in_range;
  logic [tcw_pkg::CELL_W-1:0] blank;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [tcw_pkg::CELL_W-1:0] wr_data;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;

  assign blank    = {attribute, tcw_pkg::CHAR_BLANK};
  assign pending  = (lin == CW'(CELLS));
  assign ridx_w   = 32'(ridx);
  assign lin_w    = 32'(lin);
  assign in_range = (ridx_w < 32'(CELLS));

  always_comb begin
    if (action == tcw_pkg::ACTION_READ) begin
      op_dec = tcw_pkg::OP_READ;
    end else begin
      case (char_code)
        tcw_pkg::CHAR_NL:  op_dec = tcw_pkg::OP_NL;
        tcw_pkg::CHAR_CR:  op_dec = tcw_pkg::OP_CR;
        tcw_pkg::CHAR_TAB: op_dec = tcw_pkg::OP_TAB;
        tcw_pkg::CHAR_BS:  op_dec = tcw_pkg::OP_BS;
        default:           op_dec = tcw_pkg::OP_CHAR;
      endcase
    end
  end

  // Cursor one cell on; the column wraps into the next row.
  always_comb begin
    if (col == CLW'(COLUMNS - 1)) begin
      adv_col   = '0;
      adv_row   = row + RW'(1);
      adv_phase = '0;
    end else begin
      adv_col   = col + CLW'(1);
      adv_row   = row;
      adv_phase = (phase == PW'(TAB_STOP - 1)) ? '0 : phase + PW'(1);
    end
  end

  always_comb begin
    stat.op        = op;
    stat.pending   = pending;
    stat.row_last  = (row >= RW'(ROWS - 1));
    stat.bs_ok     = !pending && (col != '0);
    stat.tab_last  = (tabcnt == TCW'(1));
    stat.copy_last = (scan == AW'(CELLS - COLUMNS - 1));
    stat.scan_last = (scan == AW'(CELLS - 1));
    stat.out_busy  = out_valid && !out_ready;
  end

  // Store write port; the controller never issues two writers at once.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = scan;
    wr_data = blank;
    if (cmd.clear_step) begin
      wr_data = RESET_CELL;
    end else if (wr_pend) begin
      wr_addr = scan_d;
      wr_data = rdata;
    end else if (cmd.blank_step) begin
      wr_addr = scan;
    end else if (cmd.put_char) begin
      wr_addr = AW'(lin);
      wr_data = {attribute, ch};
    end else if (cmd.put_tab) begin
      wr_addr = AW'(lin);
    end else if (cmd.bs) begin
      wr_addr = AW'(lin - CW'(1));
    end else begin
      wr_en = 1'b0;
    end
  end

  // Store read port: the row below during a scroll, else the requested cell.
  assign rd_en   = cmd.copy_step || cmd.rd;
  assign rd_addr = cmd.copy_step ? AW'(scan + AW'(COLUMNS)) : ridx_w[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op   <= op_dec;
      ch   <= char_code;
      ridx <= read_index;
    end
    scan_d <= scan;
    if (cmd.tab_load) begin
      tabcnt <= TCW'(TAB_STOP) - TCW'(phase);
    end else if (cmd.put_tab) begin
      tabcnt <= tabcnt - TCW'(1);
    end
    if (cmd.finish) begin
      cursor_position <= lin_w[tcw_pkg::CURSOR_W-1:0];
      scrolled        <= scroll_flag;
      read_cell       <= (op == tcw_pkg::OP_READ && in_range) ? rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lin         <= '0;
      row         <= '0;
      col         <= '0;
      phase       <= '0;
      scan        <= '0;
      wr_pend     <= 1'b0;
      scroll_flag <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      wr_pend <= cmd.copy_step;

      if (cmd.scroll_start) begin
        scan <= '0;
      end else if (cmd.clear_step || cmd.copy_step || cmd.blank_step) begin
        scan <= scan + AW'(1);
      end

      if (cmd.latch) begin
        scroll_flag <= 1'b0;
      end else if (cmd.scroll_done) begin
        scroll_flag <= 1'b1;
      end

      if (cmd.scroll_done) begin
        lin   <= CW'(CELLS - COLUMNS);
        row   <= RW'(ROWS - 1);
        col   <= '0;
        phase <= '0;
      end else if (cmd.nl) begin
        lin   <= lin - CW'(col) + CW'(COLUMNS);
        row   <= row + RW'(1);
        col   <= '0;
        phase <= '0;
      end else if (cmd.cr) begin
        lin   <= lin - CW'(col);
        col   <= '0;
        phase <= '0;
      end else if (cmd.bs) begin
        lin   <= lin - CW'(1);
        col   <= col - CLW'(1);
        phase <= (phase == '0) ? PW'(TAB_STOP - 1) : phase - PW'(1);
      end else if (cmd.put_char || cmd.put_tab) begin
        lin   <= lin + CW'(1);
        row   <= adv_row;
        col   <= adv_col;
        phase <= adv_phase;
      end

      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== bench/tcw_checker.sv =====
// Checker for the text console character writer: screen predictor and result comparison.
`timescale 1ns / 1ps

module tcw_checker #(
  parameter int                               COLUMNS   = 80,
  parameter int                               ROWS      = 25,
  parameter int                               TAB_STOP  = 8,
  parameter logic [tcw_pkg::APB_ADDR_W-1:0]   ATTR_ADDR = '0
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  tcw_item_if                                 item_mon,
  tcw_result_if                               result_mon,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic                           pready,
  input  wire logic [tcw_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [tcw_pkg::APB_DATA_W-1:0] pwdata,
  input  wire logic [tcw_pkg::APB_DATA_W-1:0] prdata,
  output int unsigned                         failures,
  output int unsigned                         awaiting
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_position;
    logic                scrolled;
    logic [CELL_W-1:0]   read_cell;
  } console_result_t;

  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cursor;
  logic [ATTR_W-1:0] attribute;
  logic              scroll_seen;
  console_result_t   expected_results [$];

  function automatic logic [CELL_W-1:0] blank_cell();
    return {attribute, CHAR_BLANK};
  endfunction

  function automatic void shift_rows_up();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = blank_cell();
    cursor = CELLS - COLUMNS;
    scroll_seen = 1'b1;
  endfunction

  function automatic console_result_t console_step(input logic [ACTION_W-1:0] act,
                                                   input logic [CHAR_W-1:0]   ch,
                                                   input logic [INDEX_W-1:0]  idx);
    console_result_t res;
    int unsigned     col;
    int unsigned     span;
    res = '0;
    scroll_seen = 1'b0;
    if (act == ACTION_READ) begin
      if (idx < CELLS) res.read_cell = screen[idx];
    end else begin
      case (ch)
        CHAR_NL: begin
          cursor = (cursor / COLUMNS + 1) * COLUMNS;
          if (cursor >= CELLS) shift_rows_up();
        end
        // A pending position (one past the last cell) stays pending.
        CHAR_CR: begin
          cursor = (cursor / COLUMNS) * COLUMNS;
        end
        CHAR_TAB: begin
          col = cursor % COLUMNS;
          span = (col / TAB_STOP + 1) * TAB_STOP - col;
          repeat (span) begin
            if (cursor >= CELLS) shift_rows_up();
            screen[cursor] = blank_cell();
            cursor++;
          end
        end
        CHAR_BS: begin
          if (cursor > 0 && cursor < CELLS && (cursor % COLUMNS) != 0) begin
            cursor--;
            screen[cursor] = blank_cell();
          end
        end
        default: begin
          if (cursor >= CELLS) shift_rows_up();
          screen[cursor] = {attribute, ch};
          cursor++;
        end
      endcase
    end
    res.cursor_position = cursor[CURSOR_W-1:0];
    res.scrolled = scroll_seen;
    return res;
  endfunction

  function automatic void report(input string field, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    failures++;
  endfunction

  always @(posedge clk) begin : watch
    console_result_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = {RESET_ATTR, CHAR_BLANK};
      cursor = 0;
      attribute = RESET_ATTR;
      expected_results.delete();
    end else begin
      if (psel && penable && pready && paddr == ATTR_ADDR) begin
        if (pwrite) begin
          attribute = pwdata[ATTR_W-1:0];
        end else if (prdata !== APB_DATA_W'(attribute)) begin
          report("attribute readback", APB_DATA_W'(attribute), prdata);
        end
      end
      // Predict before popping, so an item and its own result at one edge still pair up.
      if (item_mon.valid && item_mon.ready) begin
        expected_results.push_back(console_step(item_mon.action, item_mon.char_code,
                                                item_mon.read_index));
      end
      if (result_mon.valid && result_mon.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item, cursor %0h scrolled %0b cell %0h", $time,
                   result_mon.cursor_position, result_mon.scrolled, result_mon.read_cell);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (result_mon.cursor_position !== want.cursor_position)
            report("cursor_position", want.cursor_position, result_mon.cursor_position);
          if (result_mon.scrolled !== want.scrolled)
            report("scrolled", want.scrolled, result_mon.scrolled);
          if (result_mon.read_cell !== want.read_cell)
            report("read_cell", want.read_cell, result_mon.read_cell);
        end
      end
    end
    awaiting = expected_results.size();
  end

endmodule

// ===== bench/tb_text_console_char_writer.sv =====
// Top of the text console character writer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_text_console_char_writer;
  import tcw_pkg::*;

  localparam int                     COLUMNS        = 80;
  localparam int                     ROWS           = 25;
  localparam int                     TAB_STOP       = 8;
  localparam logic [APB_ADDR_W-1:0]  ADDR_ATTRIBUTE = '0;
  localparam logic [ACTION_W-1:0]    ACTION_PUT     = ~ACTION_READ;
  localparam int unsigned            CYCLE_LIMIT    = 4_000_000;
  localparam int                     DRAIN_CYCLES   = 64;
  localparam int unsigned            PHASE_ITEMS    = 96;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int unsigned           failures;
  int unsigned           awaiting;
  int unsigned           cycles;
  int unsigned           sent;
  int unsigned           taken;

  tcw_item_if   item_ch ();
  tcw_result_if result_ch ();

  text_console_char_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  tcw_checker #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP),
    .ATTR_ADDR(ADDR_ATTRIBUTE)
  ) console_check (
    .clk       (clk),
    .rst       (rst),
    .item_mon  (item_ch),
    .result_mon(result_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .failures  (failures),
    .awaiting  (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver stalls a random number of cycles before each result item, except in
  // every third stretch of 32 results, where it takes them back to back.
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    taken = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= (hold == 0);
      @(posedge clk);
      if (result_ch.valid && result_ch.ready) begin
        taken++;
        hold = ((taken / 32) % 3 == 2) ? 0 : $urandom_range(0, 15);
      end else if (hold > 0) begin
        hold--;
      end
    end
  end

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [CHAR_W-1:0] ch,
                           input logic [INDEX_W-1:0] idx);
    int unsigned gap;
    gap = ((sent / 40) % 3 == 1) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_ch.valid      <= 1'b1;
    item_ch.action     <= act;
    item_ch.char_code  <= ch;
    item_ch.read_index <= idx;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_item(ACTION_PUT, ch, INDEX_W'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input logic [INDEX_W-1:0] idx);
    send_item(ACTION_READ, CHAR_W'($urandom_range(0, 255)), idx);
  endtask

  function automatic logic [CHAR_W-1:0] text_char();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(0, 255));
    while (c == CHAR_NL || c == CHAR_CR || c == CHAR_TAB || c == CHAR_BS)
      c = CHAR_W'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] any_char();
    case ($urandom_range(0, 7))
      0: return CHAR_NL;
      1: return CHAR_CR;
      2: return CHAR_TAB;
      3: return CHAR_BS;
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper data bits are random; only the low byte belongs to the register.
  task automatic set_attribute(input logic [ATTR_W-1:0] attr);
    apb_access(1'b1, ADDR_ATTRIBUTE, {24'($urandom()), attr});
    apb_access(1'b0, ADDR_ATTRIBUTE, '0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Walk down to the bottom row, tab to the end of it so that a scroll is pending,
  // then hit the pending position with one item of any kind.
  task automatic fill_to_pending();
    repeat (ROWS) put_char(CHAR_NL);
    repeat (COLUMNS / TAB_STOP) put_char(CHAR_TAB);
    case ($urandom_range(0, 5))
      0: put_char(CHAR_CR);
      1: put_char(CHAR_BS);
      2: put_char(CHAR_NL);
      3: put_char(CHAR_TAB);
      4: put_char(text_char());
      default: read_cell(INDEX_W'(COLUMNS * ROWS - 1));
    endcase
  endtask

  task automatic run_random_phase(input int unsigned quota);
    int unsigned start;
    int unsigned kind;
    start = sent;
    fill_to_pending();
    while (sent - start < quota) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        repeat ($urandom_range(1, 20)) put_char(text_char());
      end else if (kind < 48) begin
        repeat ($urandom_range(1, 12)) put_char(CHAR_TAB);
      end else if (kind < 58) begin
        repeat ($urandom_range(1, 12)) put_char(CHAR_NL);
      end else if (kind < 68) begin
        repeat ($urandom_range(1, 6)) put_char(text_char());
        repeat ($urandom_range(1, 8)) put_char(CHAR_BS);
      end else if (kind < 78) begin
        repeat ($urandom_range(1, 6)) read_cell(INDEX_W'($urandom_range(0, COLUMNS * ROWS - 1)));
      end else if (kind < 80) begin
        fill_to_pending();
      end else begin
        send_item(ACTION_W'($urandom_range(0, 1)), any_char(),
                  INDEX_W'($urandom_range(0, 2047)));
      end
    end
  endtask

  initial begin : stimulus
    logic [ATTR_W-1:0] phase_attr [4];
    sent = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.action = ACTION_PUT;
    item_ch.char_code = '0;
    item_ch.read_index = '0;
    phase_attr[0] = 8'h00;
    phase_attr[1] = ATTR_W'($urandom_range(1, 254));
    phase_attr[2] = ATTR_W'($urandom_range(0, 255));
    phase_attr[3] = RESET_ATTR;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Freshly cleared store, with reads just inside and just outside the screen.
    read_cell(0);
    read_cell(INDEX_W'(COLUMNS * ROWS - 1));
    read_cell(INDEX_W'(COLUMNS * ROWS));
    read_cell('1);
    wait_drained();
    apb_access(1'b0, ADDR_ATTRIBUTE, '0);
    set_attribute(8'hFF);

    put_char(CHAR_BS);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CHAR_BS);
    put_char(CHAR_TAB);
    put_char(CHAR_TAB);
    put_char(CHAR_CR);
    put_char(CHAR_NL);
    put_char(8'h41);
    read_cell(INDEX_W'(COLUMNS));
    read_cell(0);
    read_cell(1);
    read_cell(INDEX_W'(TAB_STOP));
    wait_drained();

    foreach (phase_attr[p]) begin
      set_attribute(phase_attr[p]);
      run_random_phase(PHASE_ITEMS);
      wait_drained();
    end

    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
